[hdl/cdo_pkg.sv]
// Shared types, constants and month-length helpers for the date offset block.
`default_nettype none

package cdo_pkg;

  // Walk year: signed, wide enough for the start year plus any offset span
  localparam int YEAR_W   = 16;
  localparam int YEAR_MAX = 9999;

  // Reciprocal of 25 for the set-up remainder: floor(y * 5243 / 2^17) = y / 25
  localparam int RECIP_25   = 5243;
  localparam int RECIP_SHIFT = 17;
  localparam int QUOT_W     = 10;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef logic [4:0] mod25_t;
  typedef logic [4:0] mlen_t;

  // Gregorian leap test from year mod 16 and year mod 25
  function automatic logic is_leap(input logic [3:0] low4, input mod25_t m25);
    is_leap = (low4[1:0] == 2'd0) && ((m25 != 5'd0) || (low4 == 4'd0));
  endfunction

  function automatic mlen_t month_len(input logic [3:0] mon, input logic leap);
    mlen_t len;
    len = 5'd31;
    if (mon == MONTH_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if ((mon == MONTH_APR) || (mon == MONTH_JUN) ||
                 (mon == MONTH_SEP) || (mon == MONTH_NOV)) begin
      len = 5'd30;
    end
    month_len = len;
  endfunction

endpackage

`default_nettype wire

[hdl/calendar_date_offset.sv]
// Gregorian date plus signed day offset, walked one month per cycle.
//
// Usage:
//   Input channel in_valid/in_stall carries start_day, start_month,
//   start_year and day_offset; an item is taken when in_valid is high and
//   in_stall low. Output channel out_valid/out_stall carries result_day,
//   result_month, result_year and year_overflow from an output register.
//   One item is worked at a time: in_stall is high from acceptance until
//   the result has been written to the output register.
//   Sequence: set-up (year mod 25 by reciprocal multiply, in ST_DIV then
//   ST_MOD), then one month step per month crossed by the walk, then a
//   finishing step that loads the output register. The month steps all
//   run through the single add/compare unit.
//   A new item may be taken while the previous result still waits in the
//   output register; if out_stall holds it, the finished walk waits too.
//   Reset (rst, synchronous) empties the output register and returns the
//   sequencer to idle.
`default_nettype none

module calendar_date_offset #(
  parameter int OFFSET_BITS = 13
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [4:0]                    start_day,
  input  wire logic [3:0]                    start_month,
  input  wire logic [13:0]                   start_year,
  input  wire logic signed [OFFSET_BITS-1:0] day_offset,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [4:0]                         result_day,
  output logic [3:0]                         result_month,
  output logic [13:0]                        result_year,
  output logic                               year_overflow
);

  localparam int DAY_W = OFFSET_BITS + 2;
  localparam int YW    = cdo_pkg::YEAR_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_WALK = 2'd3;

  logic [1:0]                      state;
  logic signed [DAY_W-1:0]         d;
  logic [3:0]                      m;
  logic signed [YW-1:0]            y;
  cdo_pkg::mod25_t                 ymod;
  logic [cdo_pkg::QUOT_W-1:0]      q;

  logic [26:0]                     recip_prod;
  logic [13:0]                     q_times_25;
  logic [13:0]                     rem_full;
  logic [3:0]                      m_clamped;

  cdo_pkg::mlen_t                  len_cur;
  cdo_pkg::mlen_t                  len_prev;
  logic [3:0]                      m_prev;
  logic signed [YW-1:0]            y_prev;
  cdo_pkg::mod25_t                 ymod_prev;
  cdo_pkg::mod25_t                 ymod_inc;
  logic                            go_fwd;
  logic                            go_back;
  logic                            out_free;
  logic                            walk_done;

  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign walk_done = (state == ST_WALK) && !go_fwd && !go_back && out_free;

  // Set-up arithmetic: quotient by reciprocal, then remainder
  assign recip_prod = 27'(y[13:0]) * 27'(cdo_pkg::RECIP_25);
  assign q_times_25 = 14'(q) * 14'd25;
  assign rem_full   = y[13:0] - q_times_25;

  always_comb begin
    if (start_month == 4'd0) begin
      m_clamped = cdo_pkg::MONTH_JAN;
    end else if (start_month > cdo_pkg::MONTH_DEC) begin
      m_clamped = cdo_pkg::MONTH_DEC;
    end else begin
      m_clamped = start_month;
    end
  end

  // Month step unit: lengths of the current and the previous month
  always_comb begin
    ymod_inc  = (ymod == 5'd24) ? 5'd0 : ymod + 5'd1;
    m_prev    = m - 4'd1;
    y_prev    = y;
    ymod_prev = ymod;
    if (m == cdo_pkg::MONTH_JAN) begin
      m_prev    = cdo_pkg::MONTH_DEC;
      y_prev    = y - YW'(1);
      ymod_prev = (ymod == 5'd0) ? 5'd24 : ymod - 5'd1;
    end
    len_cur  = cdo_pkg::month_len(m, cdo_pkg::is_leap(y[3:0], ymod));
    len_prev = cdo_pkg::month_len(m_prev, cdo_pkg::is_leap(y_prev[3:0], ymod_prev));
    go_fwd   = d > $signed({{(DAY_W-5){1'b0}}, len_cur});
    go_back  = d < $signed(DAY_W'(1));
  end

  // Sequencer and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Output register: filled by a finished walk, emptied once taken
      if (walk_done) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            d     <= $signed({{(DAY_W-5){1'b0}}, start_day}) + DAY_W'(day_offset);
            m     <= m_clamped;
            y     <= $signed({{(YW-14){1'b0}}, start_year});
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          q     <= recip_prod[cdo_pkg::RECIP_SHIFT +: cdo_pkg::QUOT_W];
          state <= ST_MOD;
        end
        ST_MOD: begin
          ymod  <= rem_full[4:0];
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (go_fwd) begin
            d <= d - $signed({{(DAY_W-5){1'b0}}, len_cur});
            if (m == cdo_pkg::MONTH_DEC) begin
              m    <= cdo_pkg::MONTH_JAN;
              y    <= y + YW'(1);
              ymod <= ymod_inc;
            end else begin
              m <= m + 4'd1;
            end
          end else if (go_back) begin
            d    <= d + $signed({{(DAY_W-5){1'b0}}, len_prev});
            m    <= m_prev;
            y    <= y_prev;
            ymod <= ymod_prev;
          end else if (out_free) begin
            // Walk finished: clamp year and load the output register
            result_day   <= d[4:0];
            result_month <= m;
            state        <= ST_IDLE;
            if (y < 0) begin
              result_year   <= 14'd0;
              year_overflow <= 1'b1;
            end else if (y > $signed(YW'(cdo_pkg::YEAR_MAX))) begin
              result_year   <= 14'(cdo_pkg::YEAR_MAX);
              year_overflow <= 1'b1;
            end else begin
              result_year   <= y[13:0];
              year_overflow <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
